// ===== sv/smas_pkg.sv =====
package smas_pkg;

  // Matrix size and derived widths
  localparam int DIM     = 4;
  localparam int CELLS   = DIM * DIM;
  localparam int IDX_W   = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int CNT_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int BANKS   = 2;
  localparam int ADDR_W  = $clog2(BANKS * CELLS);
  localparam int ELEM_W  = 16;
  localparam int TERM_W  = 32;
  localparam int ACC_W   = 36;
  localparam int OUT_W   = 34;
  localparam int POS_W   = 3;
  localparam int MODE_W  = 2;

  // Result queue
  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);
  // items that may be between issue and the result queue, plus the one issued
  localparam int OQ_INFLIGHT = 3;

  // Job queue between front and back
  localparam int JQ_DEPTH = 2;
  localparam int JQ_CNT_W = $clog2(JQ_DEPTH + 1);

  // Mode register bits: bit 1 selects the product, else bit 0 selects subtract
  localparam int MODE_MUL_BIT = 1;
  localparam int MODE_SUB_BIT = 0;
  localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;

  // Output saturation bounds
  localparam logic signed [ACC_W-1:0] VAL_MAX = ACC_W'(64'sd8589934591);
  localparam logic signed [ACC_W-1:0] VAL_MIN = ACC_W'(-64'sd8589934592);

  typedef struct packed {
    logic signed [ELEM_W-1:0] a_value;
    logic signed [ELEM_W-1:0] b_value;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] value_out;
    logic [POS_W-1:0]        row_out;
    logic [POS_W-1:0]        col_out;
    logic                    last_out;
  } out_item_t;

  typedef struct packed {
    logic              bank;
    logic [MODE_W-1:0] mode;
  } job_t;

  // Front to back: head of the job queue
  typedef struct packed {
    logic valid;
    job_t job;
  } job_head_t;

  // Back to front: job taken, bank finished
  typedef struct packed {
    logic job_pop;
    logic rel_valid;
    logic rel_bank;
  } back_req_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

// ===== sv/smas_ram.sv =====
module smas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/smas_front.sv =====
module smas_front
  import smas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  in_item_t              in_item,
  input  logic                  cfg_we,
  input  logic [MODE_W-1:0]     cfg_wdata,
  output logic                  wr_en,
  output logic [ADDR_W-1:0]     wr_addr,
  output logic [ELEM_W-1:0]     wr_a,
  output logic [ELEM_W-1:0]     wr_b,
  output job_head_t             head,
  input  back_req_t             req
);

  logic [MODE_W-1:0]   op_mode_r;
  logic [CNT_W-1:0]    load_cnt_r;
  logic                wr_bank_r;
  logic [BANKS-1:0]    busy_r;
  job_t                jq_mem_r [JQ_DEPTH];
  logic                jq_wr_ptr_r;
  logic                jq_rd_ptr_r;
  logic [JQ_CNT_W-1:0] jq_count_r;
  logic                accept;
  logic                load_done;
  logic                job_push;

  // a bank still owned by the back end cannot be refilled
  assign in_full   = busy_r[wr_bank_r];
  assign accept    = in_push && !in_full;
  assign load_done = (load_cnt_r == CNT_W'(CELLS - 1));
  assign job_push  = accept && load_done;

  // store write port
  assign wr_en   = accept;
  assign wr_addr = ADDR_W'(wr_bank_r) * ADDR_W'(CELLS) + ADDR_W'(load_cnt_r);
  assign wr_a    = in_item.a_value;
  assign wr_b    = in_item.b_value;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r <= MODE_ADD;
    end else if (cfg_we) begin
      op_mode_r <= cfg_wdata;
    end
  end

  // load counter and bank toggle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
      wr_bank_r  <= 1'b0;
    end else if (accept) begin
      if (load_done) begin
        load_cnt_r <= '0;
        wr_bank_r  <= !wr_bank_r;
      end else begin
        load_cnt_r <= load_cnt_r + 1'b1;
      end
    end
  end

  // bank ownership
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else begin
      if (job_push) begin
        busy_r[wr_bank_r] <= 1'b1;
      end
      if (req.rel_valid) begin
        busy_r[req.rel_bank] <= 1'b0;
      end
    end
  end

  // job queue
  always_ff @(posedge clk) begin
    if (job_push) begin
      jq_mem_r[jq_wr_ptr_r].bank <= wr_bank_r;
      jq_mem_r[jq_wr_ptr_r].mode <= op_mode_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jq_wr_ptr_r <= 1'b0;
      jq_rd_ptr_r <= 1'b0;
      jq_count_r  <= '0;
    end else begin
      if (job_push) begin
        jq_wr_ptr_r <= !jq_wr_ptr_r;
      end
      if (req.job_pop) begin
        jq_rd_ptr_r <= !jq_rd_ptr_r;
      end
      if (job_push && !req.job_pop) begin
        jq_count_r <= jq_count_r + 1'b1;
      end else if (!job_push && req.job_pop) begin
        jq_count_r <= jq_count_r - 1'b1;
      end
    end
  end

  assign head.valid = (jq_count_r != '0);
  assign head.job   = jq_mem_r[jq_rd_ptr_r];

  // checks
  a_jq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> (jq_count_r != JQ_CNT_W'(JQ_DEPTH)))
    else $error("job queue overflow");

  a_rel_owned: assert property (@(posedge clk) disable iff (!rst_n)
    req.rel_valid |-> busy_r[req.rel_bank])
    else $error("release of a bank that is not owned");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    req.job_pop |-> head.valid)
    else $error("job taken from empty queue");

endmodule

// ===== sv/smas_back.sv =====
module smas_back
  import smas_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  job_head_t           head,
  output back_req_t           req,
  output logic [ADDR_W-1:0]   rd_addr_a,
  output logic [ADDR_W-1:0]   rd_addr_b,
  input  logic [ELEM_W-1:0]   rd_a,
  input  logic [ELEM_W-1:0]   rd_b,
  input  logic [OQ_CNT_W-1:0] oq_level,
  output logic                res_push,
  output out_item_t           res_item
);

  back_state_t state_r, state_nxt;

  logic              bank_r;
  logic [MODE_W-1:0] mode_r;
  logic [IDX_W-1:0]  r_r, c_r, k_r;
  logic [IDX_W-1:0]  k_max;
  logic              credit;
  logic              issue;
  logic              last_k;
  logic              final_issue;
  logic              job_pop;

  // stage 1: read in flight
  logic              s1_valid_r;
  logic              s1_first_r, s1_last_r;
  logic [MODE_W-1:0] s1_mode_r;
  logic [IDX_W-1:0]  s1_r_r, s1_c_r;

  // stage 2: term registered
  logic                     s2_valid_r;
  logic                     s2_first_r, s2_last_r;
  logic [IDX_W-1:0]         s2_r_r, s2_c_r;
  logic signed [TERM_W-1:0] term_r, term_nxt;

  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  acc_sat;
  logic signed [ELEM_W-1:0] a_s, b_s;
  logic [ADDR_W-1:0]        base;

  assign k_max       = mode_r[MODE_MUL_BIT] ? IDX_W'(DIM - 1) : '0;
  assign last_k      = (k_r == k_max);
  assign credit      = (oq_level <= OQ_CNT_W'(OQ_DEPTH - OQ_INFLIGHT));
  assign final_issue = last_k && (c_r == IDX_W'(DIM - 1)) && (r_r == IDX_W'(DIM - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (head.valid) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (credit && final_issue) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    job_pop = 1'b0;
    issue   = 1'b0;
    case (state_r)
      BK_IDLE: job_pop = head.valid;
      BK_RUN:  issue   = credit;
      default: begin
        job_pop = 1'b0;
        issue   = 1'b0;
      end
    endcase
  end

  assign req.job_pop   = job_pop;
  assign req.rel_valid = issue && final_issue;
  assign req.rel_bank  = bank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // job latch and row/column/step counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
      mode_r <= MODE_ADD;
      r_r    <= '0;
      c_r    <= '0;
      k_r    <= '0;
    end else if (job_pop) begin
      bank_r <= head.job.bank;
      mode_r <= head.job.mode;
      r_r    <= '0;
      c_r    <= '0;
      k_r    <= '0;
    end else if (issue) begin
      if (last_k) begin
        k_r <= '0;
        if (c_r == IDX_W'(DIM - 1)) begin
          c_r <= '0;
          if (r_r != IDX_W'(DIM - 1)) begin
            r_r <= r_r + 1'b1;
          end
        end else begin
          c_r <= c_r + 1'b1;
        end
      end else begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  // read addresses: row of the first, column of the second; one shared cell when not multiplying
  assign base = ADDR_W'(bank_r) * ADDR_W'(CELLS);
  always_comb begin
    if (mode_r[MODE_MUL_BIT]) begin
      rd_addr_a = base + ADDR_W'(r_r) * ADDR_W'(DIM) + ADDR_W'(k_r);
      rd_addr_b = base + ADDR_W'(k_r) * ADDR_W'(DIM) + ADDR_W'(c_r);
    end else begin
      rd_addr_a = base + ADDR_W'(r_r) * ADDR_W'(DIM) + ADDR_W'(c_r);
      rd_addr_b = rd_addr_a;
    end
  end

  // stage 1 tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= (k_r == '0);
    s1_last_r  <= last_k;
    s1_mode_r  <= mode_r;
    s1_r_r     <= r_r;
    s1_c_r     <= c_r;
  end

  // term: product, difference or sum
  assign a_s = $signed(rd_a);
  assign b_s = $signed(rd_b);
  always_comb begin
    if (s1_mode_r[MODE_MUL_BIT]) begin
      term_nxt = TERM_W'(a_s) * TERM_W'(b_s);
    end else if (s1_mode_r[MODE_SUB_BIT]) begin
      term_nxt = TERM_W'(a_s) - TERM_W'(b_s);
    end else begin
      term_nxt = TERM_W'(a_s) + TERM_W'(b_s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    term_r     <= term_nxt;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_r_r     <= s1_r_r;
    s2_c_r     <= s1_c_r;
  end

  // accumulate and saturate
  assign acc_nxt = s2_first_r ? ACC_W'(term_r) : acc_r + ACC_W'(term_r);

  always_comb begin
    if (acc_nxt > VAL_MAX) begin
      acc_sat = VAL_MAX;
    end else if (acc_nxt < VAL_MIN) begin
      acc_sat = VAL_MIN;
    end else begin
      acc_sat = acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign res_push           = s2_valid_r && s2_last_r;
  assign res_item.value_out = OUT_W'(acc_sat);
  assign res_item.row_out   = POS_W'(s2_r_r);
  assign res_item.col_out   = POS_W'(s2_c_r);
  assign res_item.last_out  = (s2_r_r == IDX_W'(DIM - 1)) && (s2_c_r == IDX_W'(DIM - 1));

  // checks
  a_pop_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (state_r == BK_RUN))
    else $error("job taken but sequencer not running");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (oq_level != OQ_CNT_W'(OQ_DEPTH)))
    else $error("result issued without queue credit");

endmodule

// ===== sv/smas_outq.sv =====
module smas_outq
  import smas_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  out_item_t           push_item,
  output logic [OQ_CNT_W-1:0] level,
  output logic                out_empty,
  input  logic                out_pop,
  output out_item_t           out_item
);

  out_item_t           mem_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OQ_CNT_W-1:0] count_r;
  logic                pop;

  assign out_empty = (count_r == '0);
  assign pop       = out_pop && !out_empty;
  assign level     = count_r;
  assign out_item  = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != OQ_CNT_W'(OQ_DEPTH)))
    else $error("result queue overflow");

endmodule

// ===== sv/small_matrix_add_sub_multiply_core.sv =====
// Loads: one item per cycle while the target bank is free; two banks let a new
//   load proceed while the previous matrix is still being worked on.
// First result of a matrix: queued job, sequencer start, store read, term register.
// Throughput: sum/difference one result per cycle while the result queue has room;
//   the product is slower, set by the single MAC unit (DIM*DIM*DIM MACs per matrix).
// Reset: synchronous, active low; clears counters, queues and op_mode (add);
//   operand stores are not cleared.
module small_matrix_add_sub_multiply_core
  import smas_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  in_item_t          in_item,
  output logic              out_empty,
  input  logic              out_pop,
  output out_item_t         out_item,
  input  logic              cfg_we,
  input  logic [MODE_W-1:0] cfg_wdata
);

  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ELEM_W-1:0]   wr_a, wr_b;
  logic [ADDR_W-1:0]   rd_addr_a, rd_addr_b;
  logic [ELEM_W-1:0]   rd_a, rd_b;
  job_head_t           head;
  back_req_t           req;
  logic [OQ_CNT_W-1:0] oq_level;
  logic                res_push;
  out_item_t           res_item;

  // loader, bank ownership and job queue
  smas_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_a      (wr_a),
    .wr_b      (wr_b),
    .head      (head),
    .req       (req)
  );

  // operand stores, two banks each
  smas_ram #(.WIDTH(ELEM_W), .DEPTH(BANKS * CELLS)) u_first_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_a),
    .raddr (rd_addr_a),
    .rdata (rd_a)
  );

  smas_ram #(.WIDTH(ELEM_W), .DEPTH(BANKS * CELLS)) u_second_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_b),
    .raddr (rd_addr_b),
    .rdata (rd_b)
  );

  // sequencer and MAC datapath
  smas_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .req       (req),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_a      (rd_a),
    .rd_b      (rd_b),
    .oq_level  (oq_level),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  // result queue
  smas_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_item (res_item),
    .level     (oq_level),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// ===== test/small_matrix_add_sub_multiply_core_tb.sv =====
module small_matrix_add_sub_multiply_core_tb
  import smas_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // mode codes beyond the package's add code
  localparam logic [MODE_W-1:0] MODE_SUB     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MUL     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_MUL_ALT = 2'd3;

  localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
  localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7fff;
  localparam longint RES_HI = 64'sd8589934591;
  localparam longint RES_LO = -64'sd8589934592;

  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_LIMIT  = 10;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  logic              in_full;
  in_item_t          in_item = '0;
  logic              out_empty;
  logic              out_pop = 1'b0;
  out_item_t         out_item;
  logic              cfg_we = 1'b0;
  logic [MODE_W-1:0] cfg_wdata = '0;

  // predictor state
  logic signed [ELEM_W-1:0] first_m  [CELLS];
  logic signed [ELEM_W-1:0] second_m [CELLS];
  int                       loaded_cnt = 0;
  logic [MODE_W-1:0]        mode_m = MODE_ADD;
  out_item_t                matrix_elems [$];
  int                       mismatch_cnt = 0;

  // idle rates in percent
  int send_gap_pct = 29;
  int recv_gap_pct = 58;

  small_matrix_add_sub_multiply_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // store one operand pair; the last pair of a matrix yields all result elements
  function automatic void load_operands(in_item_t it);
    out_item_t elem;
    longint    acc;
    int        r;
    int        c;
    int        k;
    first_m[loaded_cnt]  = it.a_value;
    second_m[loaded_cnt] = it.b_value;
    loaded_cnt++;
    if (loaded_cnt < CELLS) return;
    loaded_cnt = 0;
    for (r = 0; r < DIM; r++) begin
      for (c = 0; c < DIM; c++) begin
        if (mode_m[MODE_MUL_BIT]) begin
          acc = 0;
          for (k = 0; k < DIM; k++)
            acc += longint'(first_m[r*DIM+k]) * longint'(second_m[k*DIM+c]);
        end else if (mode_m[MODE_SUB_BIT]) begin
          acc = longint'(first_m[r*DIM+c]) - longint'(second_m[r*DIM+c]);
        end else begin
          acc = longint'(first_m[r*DIM+c]) + longint'(second_m[r*DIM+c]);
        end
        // clamp to the output range
        if (acc > RES_HI) acc = RES_HI;
        if (acc < RES_LO) acc = RES_LO;
        elem.value_out = acc[OUT_W-1:0];
        elem.row_out   = POS_W'(r);
        elem.col_out   = POS_W'(c);
        elem.last_out  = (r == DIM - 1) && (c == DIM - 1);
        matrix_elems.push_back(elem);
      end
    end
  endfunction

  function automatic void check_element(out_item_t got);
    out_item_t want;
    if (matrix_elems.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_LIMIT)
        $display("%0t: unexpected element value %0d row %0d col %0d last %0b",
                 $realtime, got.value_out, got.row_out, got.col_out, got.last_out);
      return;
    end
    want = matrix_elems.pop_front();
    if (got.value_out !== want.value_out || got.row_out !== want.row_out ||
        got.col_out !== want.col_out || got.last_out !== want.last_out) begin
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_LIMIT)
        $display("%0t: element mismatch exp %0d (%0d,%0d) last %0b, got %0d (%0d,%0d) last %0b",
                 $realtime, want.value_out, want.row_out, want.col_out, want.last_out,
                 got.value_out, got.row_out, got.col_out, got.last_out);
    end
  endfunction

  // monitor: register writes, accepted items and accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) mode_m = cfg_wdata;
      if (in_push && !in_full) load_operands(in_item);
      if (out_pop && !out_empty) check_element(out_item);
    end
  end

  // result side stalls at random
  always @(posedge clk) begin
    out_pop <= rst_n && ($urandom_range(99) >= recv_gap_pct);
  end

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // wait until every expected element has come out and the block has settled
  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (matrix_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic [MODE_W-1:0] m);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic signed [ELEM_W-1:0] pick_element();
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0:       return ELEM_MIN;
        1:       return ELEM_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    return ELEM_W'($urandom);
  endfunction

  // corner values indexed by two bits of the element position
  function automatic logic signed [ELEM_W-1:0] corner_value(input logic [1:0] sel);
    case (sel)
      2'd0:    return ELEM_MIN;
      2'd1:    return ELEM_MAX;
      2'd2:    return '0;
      default: return '1;
    endcase
  endfunction

  task automatic send_corner_matrix();
    in_item_t it;
    int       i;
    for (i = 0; i < CELLS; i++) begin
      it.a_value = corner_value(i[1:0]);
      it.b_value = corner_value(i[3:2]);
      send_item(it);
    end
  endtask

  // mode straight after reset must be add
  task automatic test_reset_mode_add();
    send_corner_matrix();
  endtask

  task automatic test_subtract_corners();
    set_mode(MODE_SUB);
    send_corner_matrix();
    set_mode(MODE_ADD);
    send_corner_matrix();
  endtask

  // largest product magnitudes; the unused code also selects the product
  task automatic test_product_extremes();
    in_item_t it;
    set_mode(MODE_MUL);
    it.a_value = ELEM_MIN;
    it.b_value = ELEM_MIN;
    repeat (CELLS) send_item(it);
    set_mode(MODE_MUL_ALT);
    it.b_value = ELEM_MAX;
    repeat (CELLS) send_item(it);
  endtask

  // whole matrices with random content, modes changed between bursts
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int item_goal);
    logic [MODE_W-1:0] mode_codes [4];
    in_item_t          it;
    int                sent;
    int                burst;
    mode_codes   = '{MODE_ADD, MODE_SUB, MODE_MUL, MODE_MUL_ALT};
    sent         = 0;
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    while (sent < item_goal) begin
      set_mode(mode_codes[$urandom_range(3)]);
      burst = $urandom_range(1, 3);
      repeat (burst * CELLS) begin
        it.a_value = pick_element();
        it.b_value = pick_element();
        send_item(it);
      end
      sent += burst * CELLS;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_mode_add();
    test_subtract_corners();
    test_product_extremes();
    test_random_traffic(29, 58, 64);
    test_random_traffic(58, 29, 64);
    test_random_traffic(0, 0, 64);
    wait_drained();
    if (mismatch_cnt == 0) begin
      $display("small_matrix_add_sub_multiply_core_tb: clean");
    end else begin
      $display("small_matrix_add_sub_multiply_core_tb: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("small_matrix_add_sub_multiply_core_tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/smas_pkg.sv
sv/smas_ram.sv
sv/smas_front.sv
sv/smas_back.sv
sv/smas_outq.sv
sv/small_matrix_add_sub_multiply_core.sv
test/small_matrix_add_sub_multiply_core_tb.sv
